[rtl/core/lorenz_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_pkg
// Shared widths, constants, control types and the step sequence of the
// Lorenz forward-Euler stepper.
// ----------------------------------------------------------------------------
package lorenz_pkg;

    // Number formats
    localparam int STATE_FRAC_BITS = 22;
    localparam int STATE_W         = 32;
    localparam int GAIN_W          = 24;
    localparam int GAIN_FRAC       = 16;
    localparam int DT_W            = 24;
    localparam int DT_FRAC         = 24;
    localparam int DER_W           = 40;
    localparam int DL_W            = 16;
    localparam int MUL_W           = 33;
    localparam int PROD_W          = 2 * MUL_W;
    localparam int ACC_W           = 64;
    localparam int XY_W            = 2 * STATE_W - STATE_FRAC_BITS;
    localparam int RZ_SHIFT        = STATE_FRAC_BITS - GAIN_FRAC;
    localparam int SCALE_FRAC      = 32;
    localparam int SCALE_K         = 42949673;

    // Configuration port
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 4;

    // Step sequencer
    localparam int SEQ_LEN = 15;
    localparam int STEP_W  = $clog2(SEQ_LEN);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEQ_LEN - 1);

    typedef logic signed [PROD_W-1:0] wide_t;
    typedef logic signed [MUL_W-1:0]  mop_t;

    localparam wide_t DER_MAX = (wide_t'(1) <<< (DER_W - 1)) - wide_t'(1);
    localparam wide_t DER_MIN = -(wide_t'(1) <<< (DER_W - 1));
    localparam wide_t S32_MAX = (wide_t'(1) <<< (STATE_W - 1)) - wide_t'(1);
    localparam wide_t S32_MIN = -(wide_t'(1) <<< (STATE_W - 1));

    localparam logic signed [STATE_W-1:0] STATE_ONE = STATE_W'(1) << STATE_FRAC_BITS;
    localparam logic signed [ACC_W-1:0]   ACC_ROUND = ACC_W'(1) << (DT_FRAC - 1);

    // Register reset values
    localparam logic [GAIN_W-1:0] SIGMA_RST = GAIN_W'(655360);
    localparam logic [GAIN_W-1:0] BETA_RST  = GAIN_W'(174758);
    localparam logic [GAIN_W-1:0] RHO_RST   = GAIN_W'(1835008);
    localparam logic [DT_W-1:0]   DT_RST    = DT_W'(16777);

    typedef enum logic [1:0] {
        REG_SIGMA,
        REG_BETA,
        REG_RHO,
        REG_DT
    } cfg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0] sigma;
        logic [GAIN_W-1:0] beta;
        logic [GAIN_W-1:0] rho;
        logic [DT_W-1:0]   dt;
    } lorenz_cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DX,     // sigma * (y - x)
        MUL_DY,     // x * (rho - z)
        MUL_XY,     // x * y
        MUL_BZ,     // beta * z
        MUL_AHI,    // dt * upper part of a derivative
        MUL_ALO,    // dt * lower 16 bits of a derivative
        MUL_SCL     // state * 0.01
    } mul_op_t;

    typedef enum logic [3:0] {
        POST_NONE,
        POST_PREP,
        POST_DX,
        POST_DY,
        POST_XY,
        POST_BZ,
        POST_AHI,
        POST_ALO,
        POST_SCL
    } post_op_t;

    typedef struct packed {
        mul_op_t  mul_op;
        axis_t    mul_axis;
        post_op_t post_op;
        axis_t    post_axis;
        logic     upd_en;
        axis_t    upd_axis;
    } uop_t;

    typedef struct packed {
        logic start;
        logic out_load;
        uop_t uop;
    } lorenz_cmd_t;

    localparam uop_t UOP_IDLE = '{
        mul_op:    MUL_NONE,
        mul_axis:  AX_X,
        post_op:   POST_NONE,
        post_axis: AX_X,
        upd_en:    1'b0,
        upd_axis:  AX_X
    };

    // Round half up, then arithmetic shift right.
    function automatic wide_t rnd_shr(input wide_t v, input int k);
        return (v + (wide_t'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic wide_t clamp(input wide_t v, input wide_t lo, input wide_t hi);
        wide_t r;
        r = v;
        if (v > hi) begin
            r = hi;
        end else if (v < lo) begin
            r = lo;
        end
        return r;
    endfunction

    function automatic logic ovf(input wide_t v, input wide_t lo, input wide_t hi);
        return (v > hi) || (v < lo);
    endfunction

    // Multiply issues in one step, the product is consumed by the post op
    // of the next step.
    function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
        uop_t u;
        u = UOP_IDLE;
        case (step)
            STEP_W'(0): begin
                u.post_op = POST_PREP;
            end
            STEP_W'(1): begin
                u.mul_op = MUL_DX;
            end
            STEP_W'(2): begin
                u.mul_op  = MUL_DY;
                u.post_op = POST_DX;
            end
            STEP_W'(3): begin
                u.mul_op  = MUL_XY;
                u.post_op = POST_DY;
            end
            STEP_W'(4): begin
                u.mul_op  = MUL_BZ;
                u.post_op = POST_XY;
            end
            STEP_W'(5): begin
                u.mul_op   = MUL_AHI;
                u.mul_axis = AX_X;
                u.post_op  = POST_BZ;
            end
            STEP_W'(6): begin
                u.mul_op   = MUL_ALO;
                u.mul_axis = AX_X;
                u.post_op  = POST_AHI;
            end
            STEP_W'(7): begin
                u.mul_op   = MUL_AHI;
                u.mul_axis = AX_Y;
                u.post_op  = POST_ALO;
            end
            STEP_W'(8): begin
                u.mul_op   = MUL_ALO;
                u.mul_axis = AX_Y;
                u.post_op  = POST_AHI;
                u.upd_en   = 1'b1;
                u.upd_axis = AX_X;
            end
            STEP_W'(9): begin
                u.mul_op   = MUL_AHI;
                u.mul_axis = AX_Z;
                u.post_op  = POST_ALO;
            end
            STEP_W'(10): begin
                u.mul_op   = MUL_ALO;
                u.mul_axis = AX_Z;
                u.post_op  = POST_AHI;
                u.upd_en   = 1'b1;
                u.upd_axis = AX_Y;
            end
            STEP_W'(11): begin
                u.mul_op   = MUL_SCL;
                u.mul_axis = AX_X;
                u.post_op  = POST_ALO;
            end
            STEP_W'(12): begin
                u.mul_op    = MUL_SCL;
                u.mul_axis  = AX_Y;
                u.post_op   = POST_SCL;
                u.post_axis = AX_X;
                u.upd_en    = 1'b1;
                u.upd_axis  = AX_Z;
            end
            STEP_W'(13): begin
                u.mul_op    = MUL_SCL;
                u.mul_axis  = AX_Z;
                u.post_op   = POST_SCL;
                u.post_axis = AX_Y;
            end
            STEP_W'(14): begin
                u.post_op   = POST_SCL;
                u.post_axis = AX_Z;
            end
            default: begin
                u = UOP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

[rtl/core/lorenz_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_cfg
// APB-style register file holding sigma, beta, rho and the time step.
// ----------------------------------------------------------------------------
module lorenz_cfg
    import lorenz_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output lorenz_cfg_t           cfg
);

    logic [GAIN_W-1:0] sigma_reg;
    logic [GAIN_W-1:0] beta_reg;
    logic [GAIN_W-1:0] rho_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [1:0]        idx;
    logic              wr_en;

    assign idx    = paddr[CFG_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= SIGMA_RST;
            beta_reg  <= BETA_RST;
            rho_reg   <= RHO_RST;
            dt_reg    <= DT_RST;
        end else if (wr_en) begin
            case (idx)
                REG_SIGMA: sigma_reg <= pwdata[GAIN_W-1:0];
                REG_BETA:  beta_reg  <= pwdata[GAIN_W-1:0];
                REG_RHO:   rho_reg   <= pwdata[GAIN_W-1:0];
                REG_DT:    dt_reg    <= pwdata[DT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SIGMA: prdata = CFG_DATA_W'(sigma_reg);
            REG_BETA:  prdata = CFG_DATA_W'(beta_reg);
            REG_RHO:   prdata = CFG_DATA_W'(rho_reg);
            REG_DT:    prdata = CFG_DATA_W'(dt_reg);
            default:   prdata = '0;
        endcase
    end

    assign cfg.sigma = sigma_reg;
    assign cfg.beta  = beta_reg;
    assign cfg.rho   = rho_reg;
    assign cfg.dt    = dt_reg;

endmodule

[rtl/core/lorenz_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_ctrl
// Controller: takes a request, runs the fixed step sequence and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module lorenz_ctrl
    import lorenz_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output lorenz_cmd_t cmd
);

    state_t              state_reg;
    state_t              state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_ready      = 1'b0;
        cmd.start    = 1'b0;
        cmd.out_load = 1'b0;
        cmd.uop      = UOP_IDLE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.uop = uop_at(step_reg);
                if (step_reg == STEP_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DONE: begin
                // hold until the output register is free or being drained
                if (!out_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_RUN && step_reg == '0))
        else $error("accepted request did not start the step sequence");

    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN && step_reg == STEP_LAST) |=> (state_reg == ST_DONE))
        else $error("sequence did not finish after the last step");

    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> ($past(state_reg) == ST_DONE))
        else $error("result appeared without a finished step");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_LAST))
        else $error("step counter ran past the sequence");

endmodule

[rtl/core/lorenz_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorenz_dp
// Datapath: state registers, one shared 33x33 multiplier with a product
// register, post-processing (round, clamp, accumulate) and output register.
// ----------------------------------------------------------------------------
module lorenz_dp
    import lorenz_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lorenz_cmd_t               cmd,
    input  logic                      restart,
    input  lorenz_cfg_t               cfg,
    output logic signed [STATE_W-1:0] point_x,
    output logic signed [STATE_W-1:0] point_y,
    output logic signed [STATE_W-1:0] point_z,
    output logic                      saturated
);

    // architectural state
    logic signed [STATE_W-1:0] pos_x_reg, pos_x_next;
    logic signed [STATE_W-1:0] pos_y_reg, pos_y_next;
    logic signed [STATE_W-1:0] pos_z_reg, pos_z_next;
    logic                      sat_reg, sat_next;

    // working registers
    mop_t                      diff_reg, diff_next;
    logic signed [STATE_W-1:0] rz_reg, rz_next;
    logic signed [DER_W-1:0]   dx_reg, dx_next;
    logic signed [DER_W-1:0]   dy_reg, dy_next;
    logic signed [DER_W-1:0]   dz_reg, dz_next;
    logic signed [XY_W-1:0]    xy_reg, xy_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [DER_W-1:0]   inc_reg, inc_next;
    wide_t                     prod_reg, prod_next;
    logic signed [STATE_W-1:0] scl_x_reg, scl_x_next;
    logic signed [STATE_W-1:0] scl_y_reg, scl_y_next;
    logic signed [STATE_W-1:0] scl_z_reg, scl_z_next;
    logic signed [STATE_W-1:0] out_x_reg, out_x_next;
    logic signed [STATE_W-1:0] out_y_reg, out_y_next;
    logic signed [STATE_W-1:0] out_z_reg, out_z_next;
    logic                      out_sat_reg, out_sat_next;

    // combinational temporaries
    mop_t                      mul_a;
    mop_t                      mul_b;
    mop_t                      dt_op;
    logic signed [DER_W-1:0]   d_sel;
    logic signed [STATE_W-1:0] pos_mul_sel;
    logic signed [STATE_W-1:0] pos_upd_sel;
    logic signed [STATE_W-1:0] pos_new;
    wide_t                     rz_w;
    wide_t                     post_w;
    wide_t                     upd_w;

    // operand selection by axis
    always_comb begin
        case (cmd.uop.mul_axis)
            AX_X: begin
                d_sel       = dx_reg;
                pos_mul_sel = pos_x_reg;
            end
            AX_Y: begin
                d_sel       = dy_reg;
                pos_mul_sel = pos_y_reg;
            end
            AX_Z: begin
                d_sel       = dz_reg;
                pos_mul_sel = pos_z_reg;
            end
            default: begin
                d_sel       = dx_reg;
                pos_mul_sel = pos_x_reg;
            end
        endcase

        case (cmd.uop.upd_axis)
            AX_X:    pos_upd_sel = pos_x_reg;
            AX_Y:    pos_upd_sel = pos_y_reg;
            AX_Z:    pos_upd_sel = pos_z_reg;
            default: pos_upd_sel = pos_x_reg;
        endcase
    end

    // shared multiplier
    assign dt_op = mop_t'($signed({1'b0, cfg.dt}));

    always_comb begin
        case (cmd.uop.mul_op)
            MUL_DX: begin
                mul_a = diff_reg;
                mul_b = mop_t'($signed(cfg.sigma));
            end
            MUL_DY: begin
                mul_a = mop_t'(pos_x_reg);
                mul_b = mop_t'(rz_reg);
            end
            MUL_XY: begin
                mul_a = mop_t'(pos_x_reg);
                mul_b = mop_t'(pos_y_reg);
            end
            MUL_BZ: begin
                mul_a = mop_t'(pos_z_reg);
                mul_b = mop_t'($signed(cfg.beta));
            end
            MUL_AHI: begin
                mul_a = mop_t'($signed(d_sel[DER_W-1:DL_W]));
                mul_b = dt_op;
            end
            MUL_ALO: begin
                mul_a = mop_t'($signed({1'b0, d_sel[DL_W-1:0]}));
                mul_b = dt_op;
            end
            MUL_SCL: begin
                mul_a = mop_t'(pos_mul_sel);
                mul_b = mop_t'(SCALE_K);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // post-processing of the previous product, state update, output load
    always_comb begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        pos_z_next   = pos_z_reg;
        sat_next     = sat_reg;
        diff_next    = diff_reg;
        rz_next      = rz_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dz_next      = dz_reg;
        xy_next      = xy_reg;
        acc_next     = acc_reg;
        inc_next     = inc_reg;
        scl_x_next   = scl_x_reg;
        scl_y_next   = scl_y_reg;
        scl_z_next   = scl_z_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        out_z_next   = out_z_reg;
        out_sat_next = out_sat_reg;

        rz_w   = (wide_t'($signed(cfg.rho)) <<< RZ_SHIFT) - wide_t'(pos_z_reg);
        post_w = '0;
        upd_w  = wide_t'(pos_upd_sel) + wide_t'(inc_reg);
        pos_new = STATE_W'(clamp(upd_w, S32_MIN, S32_MAX));

        if (cmd.start) begin
            sat_next = 1'b0;
            if (restart) begin
                pos_x_next = STATE_ONE;
                pos_y_next = STATE_ONE;
                pos_z_next = STATE_ONE;
            end
        end

        case (cmd.uop.post_op)
            POST_PREP: begin
                diff_next = mop_t'(pos_y_reg) - mop_t'(pos_x_reg);
                rz_next   = STATE_W'(clamp(rz_w, S32_MIN, S32_MAX));
                sat_next  = sat_next | ovf(rz_w, S32_MIN, S32_MAX);
            end
            POST_DX: begin
                post_w   = rnd_shr(prod_reg, GAIN_FRAC);
                dx_next  = DER_W'(clamp(post_w, DER_MIN, DER_MAX));
                sat_next = sat_next | ovf(post_w, DER_MIN, DER_MAX);
            end
            POST_DY: begin
                post_w   = rnd_shr(prod_reg, STATE_FRAC_BITS) - wide_t'(pos_y_reg);
                dy_next  = DER_W'(clamp(post_w, DER_MIN, DER_MAX));
                sat_next = sat_next | ovf(post_w, DER_MIN, DER_MAX);
            end
            POST_XY: begin
                post_w  = rnd_shr(prod_reg, STATE_FRAC_BITS);
                xy_next = XY_W'(post_w);
            end
            POST_BZ: begin
                post_w   = wide_t'(xy_reg) - rnd_shr(prod_reg, GAIN_FRAC);
                dz_next  = DER_W'(clamp(post_w, DER_MIN, DER_MAX));
                sat_next = sat_next | ovf(post_w, DER_MIN, DER_MAX);
            end
            POST_AHI: begin
                // fold the rounding half LSB of the dt product in here
                acc_next = ACC_W'(prod_reg <<< DL_W) + ACC_ROUND;
            end
            POST_ALO: begin
                post_w   = wide_t'(acc_reg) + prod_reg;
                inc_next = DER_W'(post_w >>> DT_FRAC);
            end
            POST_SCL: begin
                post_w = rnd_shr(prod_reg, SCALE_FRAC);
                case (cmd.uop.post_axis)
                    AX_X:    scl_x_next = STATE_W'(post_w);
                    AX_Y:    scl_y_next = STATE_W'(post_w);
                    AX_Z:    scl_z_next = STATE_W'(post_w);
                    default: scl_x_next = STATE_W'(post_w);
                endcase
            end
            default: begin
            end
        endcase

        if (cmd.uop.upd_en) begin
            sat_next = sat_next | ovf(upd_w, S32_MIN, S32_MAX);
            case (cmd.uop.upd_axis)
                AX_X:    pos_x_next = pos_new;
                AX_Y:    pos_y_next = pos_new;
                AX_Z:    pos_z_next = pos_new;
                default: pos_x_next = pos_new;
            endcase
        end

        if (cmd.out_load) begin
            out_x_next   = scl_x_reg;
            out_y_next   = scl_y_reg;
            out_z_next   = scl_z_reg;
            out_sat_next = sat_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg <= STATE_ONE;
            pos_y_reg <= STATE_ONE;
            pos_z_reg <= STATE_ONE;
            sat_reg   <= 1'b0;
        end else begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            pos_z_reg <= pos_z_next;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg    <= diff_next;
        rz_reg      <= rz_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dz_reg      <= dz_next;
        xy_reg      <= xy_next;
        acc_reg     <= acc_next;
        inc_reg     <= inc_next;
        prod_reg    <= prod_next;
        scl_x_reg   <= scl_x_next;
        scl_y_reg   <= scl_y_next;
        scl_z_reg   <= scl_z_next;
        out_x_reg   <= out_x_next;
        out_y_reg   <= out_y_next;
        out_z_reg   <= out_z_next;
        out_sat_reg <= out_sat_next;
    end

    assign point_x   = out_x_reg;
    assign point_y   = out_y_reg;
    assign point_z   = out_z_reg;
    assign saturated = out_sat_reg;

endmodule

[rtl/core/lorenz_euler_stepper.sv]
`timescale 1ns / 1ps
// m_valid rises once the step sequence has run and DONE has loaded the output register;
// DONE waits while a result is still held and m_ready is low. Requests are stepped one at
// a time, as the single shared 33x33 multiplier carries the 13 products of a step in
// sequence. A new request is taken while the previous result waits in the output register.
// Reset (aresetn low, synchronous) loads the gains and time step defaults
// and sets the state to x = y = z = 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
// lorenz_euler_stepper
// Fixed-point forward-Euler stepper of the Lorenz system with an APB-style
// register port for sigma, beta, rho and dt.
// ----------------------------------------------------------------------------
module lorenz_euler_stepper
    import lorenz_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [CFG_ADDR_W-1:0]     paddr,
    input  logic [CFG_DATA_W-1:0]     pwdata,
    output logic [CFG_DATA_W-1:0]     prdata,
    output logic                      pready,
    // step requests
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_restart,
    // results
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [STATE_W-1:0] m_point_x,
    output logic signed [STATE_W-1:0] m_point_y,
    output logic signed [STATE_W-1:0] m_point_z,
    output logic                      m_saturated
);

    lorenz_cfg_t cfg;
    lorenz_cmd_t cmd;

    lorenz_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lorenz_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lorenz_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .restart   (s_restart),
        .cfg       (cfg),
        .point_x   (m_point_x),
        .point_y   (m_point_y),
        .point_z   (m_point_z),
        .saturated (m_saturated)
    );

endmodule
